>>> rtl/core/pewb_pkg.sv
`timescale 1ns / 1ps

package pewb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int SCALE_W   = 17;
    localparam int EXT_W     = 31;
    localparam int PROD_W    = DATA_W + SCALE_W + 1;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

    localparam logic [SCALE_W-1:0] TIME_STEP_RST = SCALE_W'(1092);
    localparam logic [EXT_W-1:0]   GRAVITY_RST   = EXT_W'(642253);
    localparam logic [SCALE_W-1:0] DAMPING_RST   = SCALE_W'(65536);
    localparam logic [EXT_W-1:0]   RADIUS_RST    = EXT_W'(65536);
    localparam logic [EXT_W-1:0]   WIDTH_RST     = EXT_W'(52428800);
    localparam logic [EXT_W-1:0]   HEIGHT_RST    = EXT_W'(39321600);

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_STEP = 3'd0,
        REG_GRAVITY   = 3'd1,
        REG_DAMPING   = 3'd2,
        REG_RADIUS    = 3'd3,
        REG_WIDTH     = 3'd4,
        REG_HEIGHT    = 3'd5
    } t_reg_idx;

    typedef logic signed [DATA_W-1:0] t_fix;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        t_fix pos_x;
        t_fix pos_y;
        t_fix vel_x;
        t_fix vel_y;
        t_fix accel_x;
        t_fix accel_y;
    } t_in;

    typedef struct packed {
        t_fix new_pos_x;
        t_fix new_pos_y;
        t_fix new_vel_x;
        t_fix new_vel_y;
        t_fix pred_x;
        t_fix pred_y;
    } t_out;

    typedef struct packed {
        t_fix px;
        t_fix py;
        t_fix vx;
        t_fix vy;
        t_fix qx;
        t_fix qy;
    } t_mid;

    typedef struct packed {
        logic [SCALE_W-1:0] dt;
        logic [EXT_W-1:0]   gravity;
        logic [SCALE_W-1:0] damping;
        logic [EXT_W-1:0]   radius;
        logic [EXT_W-1:0]   width;
        logic [EXT_W-1:0]   height;
    } t_cfg;

    typedef struct packed {
        logic hit;
        t_fix val;
    } t_wall;

    function automatic t_fix sat_add(input t_fix a, input t_fix b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] == s[DATA_W-1]) begin
            return s[DATA_W-1:0];
        end
        return s[DATA_W] ? DATA_MIN : DATA_MAX;
    endfunction

    function automatic t_fix sat_sub_u(input t_fix a, input logic [EXT_W-1:0] b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {{(DATA_W+1-EXT_W){1'b0}}, b};
        if (s[DATA_W] == s[DATA_W-1]) begin
            return s[DATA_W-1:0];
        end
        return s[DATA_W] ? DATA_MIN : DATA_MAX;
    endfunction

    function automatic t_fix neg_sat(input t_fix a);
        if (a == DATA_MIN) begin
            return DATA_MAX;
        end
        return -a;
    endfunction

    function automatic t_prod mul_raw(input t_fix a, input logic [SCALE_W-1:0] b);
        logic signed [SCALE_W:0] bs;
        bs = {1'b0, b};
        return t_prod'(a) * t_prod'(bs);
    endfunction

    function automatic t_fix mul_round(input t_prod p);
        t_prod t;
        t_prod sh;
        t  = p + ROUND_HALF;
        sh = t >>> FRAC_BITS;
        if ((&sh[PROD_W-1:DATA_W-1]) || !(|sh[PROD_W-1:DATA_W-1])) begin
            return sh[DATA_W-1:0];
        end
        return sh[PROD_W-1] ? DATA_MIN : DATA_MAX;
    endfunction

    function automatic t_wall wall_test(input t_fix p, input logic [EXT_W-1:0] ext,
                                        input logic [EXT_W-1:0] rad);
        logic signed [DATA_W+1:0] lo;
        logic signed [DATA_W+1:0] hi;
        logic signed [DATA_W+1:0] lim;
        t_wall w;
        lo  = {{2{p[DATA_W-1]}}, p} - {{(DATA_W+2-EXT_W){1'b0}}, rad};
        hi  = {{2{p[DATA_W-1]}}, p} + {{(DATA_W+2-EXT_W){1'b0}}, rad};
        lim = {{(DATA_W+2-EXT_W){1'b0}}, ext};
        if (lo[DATA_W+1]) begin
            w.hit = 1'b1;
            w.val = {{(DATA_W-EXT_W){1'b0}}, rad};
        end else if (hi >= lim) begin
            w.hit = 1'b1;
            w.val = {{(DATA_W-EXT_W){1'b0}}, ext} - {{(DATA_W-EXT_W){1'b0}}, rad};
        end else begin
            w.hit = 1'b0;
            w.val = p;
        end
        return w;
    endfunction

endpackage

>>> rtl/core/pewb_step.sv
`timescale 1ns / 1ps

module pewb_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  pewb_pkg::t_in   i_item,
    input  pewb_pkg::t_cfg  i_cfg,
    output logic            o_vld,
    output pewb_pkg::t_mid  o_mid
);

    localparam int STAGES = 7;

    logic [STAGES-1:0] r_vld;

    pewb_pkg::t_in   r1_in;
    pewb_pkg::t_in   r2_in;
    pewb_pkg::t_prod r2_pax, r2_pay, r2_pqx, r2_pqy;
    pewb_pkg::t_in   r3_in;
    pewb_pkg::t_fix  r3_max, r3_may, r3_mqx, r3_mqy;
    pewb_pkg::t_mid  r4_mid;
    pewb_pkg::t_mid  r5_mid;
    pewb_pkg::t_prod r5_pvx, r5_pvy;
    pewb_pkg::t_mid  r6_mid;
    pewb_pkg::t_fix  r6_mvx, r6_mvy;
    pewb_pkg::t_mid  r7_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // net y acceleration
            r1_in.pos_x   <= i_item.pos_x;
            r1_in.pos_y   <= i_item.pos_y;
            r1_in.vel_x   <= i_item.vel_x;
            r1_in.vel_y   <= i_item.vel_y;
            r1_in.accel_x <= i_item.accel_x;
            r1_in.accel_y <= pewb_pkg::sat_sub_u(i_item.accel_y, i_cfg.gravity);

            r2_in  <= r1_in;
            r2_pax <= pewb_pkg::mul_raw(r1_in.accel_x, i_cfg.dt);
            r2_pay <= pewb_pkg::mul_raw(r1_in.accel_y, i_cfg.dt);
            r2_pqx <= pewb_pkg::mul_raw(r1_in.vel_x, i_cfg.dt);
            r2_pqy <= pewb_pkg::mul_raw(r1_in.vel_y, i_cfg.dt);

            r3_in  <= r2_in;
            r3_max <= pewb_pkg::mul_round(r2_pax);
            r3_may <= pewb_pkg::mul_round(r2_pay);
            r3_mqx <= pewb_pkg::mul_round(r2_pqx);
            r3_mqy <= pewb_pkg::mul_round(r2_pqy);

            r4_mid.px <= r3_in.pos_x;
            r4_mid.py <= r3_in.pos_y;
            r4_mid.vx <= pewb_pkg::sat_add(r3_in.vel_x, r3_max);
            r4_mid.vy <= pewb_pkg::sat_add(r3_in.vel_y, r3_may);
            r4_mid.qx <= pewb_pkg::sat_add(r3_in.pos_x, r3_mqx);
            r4_mid.qy <= pewb_pkg::sat_add(r3_in.pos_y, r3_mqy);

            r5_mid <= r4_mid;
            r5_pvx <= pewb_pkg::mul_raw(r4_mid.vx, i_cfg.dt);
            r5_pvy <= pewb_pkg::mul_raw(r4_mid.vy, i_cfg.dt);

            r6_mid <= r5_mid;
            r6_mvx <= pewb_pkg::mul_round(r5_pvx);
            r6_mvy <= pewb_pkg::mul_round(r5_pvy);

            r7_mid.px <= pewb_pkg::sat_add(r6_mid.px, r6_mvx);
            r7_mid.py <= pewb_pkg::sat_add(r6_mid.py, r6_mvy);
            r7_mid.vx <= r6_mid.vx;
            r7_mid.vy <= r6_mid.vy;
            r7_mid.qx <= r6_mid.qx;
            r7_mid.qy <= r6_mid.qy;
        end
    end

    assign o_vld = r_vld[STAGES-1];
    assign o_mid = r7_mid;

endmodule

>>> rtl/core/pewb_bounce.sv
`timescale 1ns / 1ps

module pewb_bounce (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  pewb_pkg::t_mid  i_mid,
    input  pewb_pkg::t_cfg  i_cfg,
    output logic            o_vld,
    output pewb_pkg::t_out  o_out
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] r_vld;

    pewb_pkg::t_wall n_wx, n_wy, n_wqx, n_wqy;

    pewb_pkg::t_mid  r1_mid;
    logic            r1_hit;
    pewb_pkg::t_mid  r2_mid;
    logic            r2_hit;
    pewb_pkg::t_prod r2_pvx, r2_pvy;
    pewb_pkg::t_mid  r3_mid;
    pewb_pkg::t_mid  r4_mid;
    logic            r4_hit;
    pewb_pkg::t_mid  r5_mid;
    logic            r5_hit;
    pewb_pkg::t_prod r5_pvx, r5_pvy;
    pewb_pkg::t_out  r6_out;

    always_comb begin
        n_wx  = pewb_pkg::wall_test(i_mid.px, i_cfg.width, i_cfg.radius);
        n_wqx = pewb_pkg::wall_test(i_mid.qx, i_cfg.width, i_cfg.radius);
        n_wqy = pewb_pkg::wall_test(i_mid.qy, i_cfg.height, i_cfg.radius);
        n_wy  = pewb_pkg::wall_test(r3_mid.py, i_cfg.height, i_cfg.radius);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // x wall and predicted clamp
            r1_hit    <= n_wx.hit;
            r1_mid.px <= n_wx.val;
            r1_mid.py <= i_mid.py;
            r1_mid.vx <= n_wx.hit ? pewb_pkg::neg_sat(i_mid.vx) : i_mid.vx;
            r1_mid.vy <= i_mid.vy;
            r1_mid.qx <= n_wqx.val;
            r1_mid.qy <= n_wqy.val;

            r2_mid <= r1_mid;
            r2_hit <= r1_hit;
            r2_pvx <= pewb_pkg::mul_raw(r1_mid.vx, i_cfg.damping);
            r2_pvy <= pewb_pkg::mul_raw(r1_mid.vy, i_cfg.damping);

            r3_mid.px <= r2_mid.px;
            r3_mid.py <= r2_mid.py;
            r3_mid.vx <= r2_hit ? pewb_pkg::mul_round(r2_pvx) : r2_mid.vx;
            r3_mid.vy <= r2_hit ? pewb_pkg::mul_round(r2_pvy) : r2_mid.vy;
            r3_mid.qx <= r2_mid.qx;
            r3_mid.qy <= r2_mid.qy;

            // y wall
            r4_hit    <= n_wy.hit;
            r4_mid.px <= r3_mid.px;
            r4_mid.py <= n_wy.val;
            r4_mid.vx <= r3_mid.vx;
            r4_mid.vy <= n_wy.hit ? pewb_pkg::neg_sat(r3_mid.vy) : r3_mid.vy;
            r4_mid.qx <= r3_mid.qx;
            r4_mid.qy <= r3_mid.qy;

            r5_mid <= r4_mid;
            r5_hit <= r4_hit;
            r5_pvx <= pewb_pkg::mul_raw(r4_mid.vx, i_cfg.damping);
            r5_pvy <= pewb_pkg::mul_raw(r4_mid.vy, i_cfg.damping);

            r6_out.new_pos_x <= r5_mid.px;
            r6_out.new_pos_y <= r5_mid.py;
            r6_out.new_vel_x <= r5_hit ? pewb_pkg::mul_round(r5_pvx) : r5_mid.vx;
            r6_out.new_vel_y <= r5_hit ? pewb_pkg::mul_round(r5_pvy) : r5_mid.vy;
            r6_out.pred_x    <= r5_mid.qx;
            r6_out.pred_y    <= r5_mid.qy;
        end
    end

    assign o_vld = r_vld[STAGES-1];
    assign o_out = r6_out;

endmodule

>>> rtl/core/particle_euler_step_wall_bounce.sv
`timescale 1ns / 1ps
// an accepted request passes through the step pipeline and then the bounce pipeline to the output
// throughput: one particle per cycle while the output is not stalled, set by a fully pipelined datapath
// a stalled output freezes every stage, so nothing is lost or repeated
// synchronous active-low reset clears all valid bits and loads register defaults

module particle_euler_step_wall_bounce (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  pewb_pkg::t_in                     i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output pewb_pkg::t_out                    o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pewb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pewb_pkg::DATA_W-1:0]       i_cfg_data
);

    pewb_pkg::t_cfg r_cfg;
    logic           w_en;
    logic           w_mid_vld;
    pewb_pkg::t_mid w_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dt      <= pewb_pkg::TIME_STEP_RST;
            r_cfg.gravity <= pewb_pkg::GRAVITY_RST;
            r_cfg.damping <= pewb_pkg::DAMPING_RST;
            r_cfg.radius  <= pewb_pkg::RADIUS_RST;
            r_cfg.width   <= pewb_pkg::WIDTH_RST;
            r_cfg.height  <= pewb_pkg::HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pewb_pkg::REG_TIME_STEP: begin
                    r_cfg.dt <= i_cfg_data[pewb_pkg::SCALE_W-1:0];
                end
                pewb_pkg::REG_GRAVITY: begin
                    r_cfg.gravity <= i_cfg_data[pewb_pkg::EXT_W-1:0];
                end
                pewb_pkg::REG_DAMPING: begin
                    r_cfg.damping <= i_cfg_data[pewb_pkg::SCALE_W-1:0];
                end
                pewb_pkg::REG_RADIUS: begin
                    r_cfg.radius <= i_cfg_data[pewb_pkg::EXT_W-1:0];
                end
                pewb_pkg::REG_WIDTH: begin
                    r_cfg.width <= i_cfg_data[pewb_pkg::EXT_W-1:0];
                end
                pewb_pkg::REG_HEIGHT: begin
                    r_cfg.height <= i_cfg_data[pewb_pkg::EXT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // whole pipe advances unless a finished result is held
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    pewb_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in_valid),
        .i_item  (i_in),
        .i_cfg   (r_cfg),
        .o_vld   (w_mid_vld),
        .o_mid   (w_mid)
    );

    pewb_bounce u_bounce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_mid_vld),
        .i_mid   (w_mid),
        .i_cfg   (r_cfg),
        .o_vld   (o_out_valid),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_mid_vld) && $stable(w_mid))
        else $error("mid pipeline moved during stall");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !w_mid_vld)
        else $error("pipeline not empty after reset");

    a_cfg_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> r_cfg.damping == pewb_pkg::DAMPING_RST
                  && r_cfg.dt == pewb_pkg::TIME_STEP_RST)
        else $error("config defaults not loaded");
`endif

endmodule
